// ===== rtl/rm2q_pkg.sv =====
// Package with the payload types and constants of the rotation matrix to quaternion core.
package rm2q_pkg;

  // Matrix elements in signed Q2.14, flat row order.
  typedef struct packed {
    logic signed [15:0] elem_0;
    logic signed [15:0] elem_1;
    logic signed [15:0] elem_2;
    logic signed [15:0] elem_3;
    logic signed [15:0] elem_4;
    logic signed [15:0] elem_5;
    logic signed [15:0] elem_6;
    logic signed [15:0] elem_7;
    logic signed [15:0] elem_8;
  } mat_t;

  // Quaternion in signed Q1.14 with status flags.
  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               improper;
    logic               bad_input;
  } quat_t;

  localparam int unsigned DivSteps  = 32;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned FrontLat  = 7;
  localparam int unsigned Latency   = FrontLat + DivSteps + SqrtSteps + 1;

  localparam logic signed [18:0] QOne = 19'sd16384;

  // One quaternion component on its way through the divider and root stages.
  typedef struct packed {
    logic        sgn;
    logic        ovf;
    logic [18:0] rem;
    logic [15:0] root;
    logic [31:0] sh;
  } lane_t;

  typedef struct packed {
    logic        neg;
    logic        bad;
    logic [16:0] tt;
    lane_t [3:0] ln;
  } pipe_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// Top level of the pipelined rotation matrix to quaternion converter.
//
// Usage: drive a 3x3 matrix of signed Q2.14 elements on in_i and raise
// start_i; the transaction is taken at the rising edge where start_i is high
// and busy_o is low. busy_o is always low, so one matrix may enter in every
// cycle.
// Each result appears on res_o for exactly one cycle with done_o high.
// Results come out in input order.
// Throughput is one matrix per cycle; the latency is set by the seven front
// stages (determinant, negation, branch, squaring, divider set-up), the 32
// restoring division stages, the 16 square root stages and the output
// register.
// The output carries the four Q1.14 components, the improper flag (negative
// determinant, matrix negated) and the bad_input flag (trace term not
// positive, components zero).
// Reset clears all valid bits, so no result is strobed until new matrices
// arrive. The receiver cannot hold results off; it must take each result in
// the cycle that done_o is high.
module rotation_matrix_to_quaternion_core
  import rm2q_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  mat_t  in_i,
  output logic  done_o,
  output quat_t res_o
);

  logic [Latency-1:0] vld_q;
  logic               acc;

  assign busy_o = 1'b0;
  assign acc    = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], acc};
    end
  end

  assign done_o = vld_q[Latency-1];

  // Stage 1: elements and the six pair products of the cofactors.
  logic signed [15:0] mi [9];
  logic signed [15:0] m1_q [9];
  logic signed [31:0] p_q [6];

  assign mi[0] = in_i.elem_0;
  assign mi[1] = in_i.elem_1;
  assign mi[2] = in_i.elem_2;
  assign mi[3] = in_i.elem_3;
  assign mi[4] = in_i.elem_4;
  assign mi[5] = in_i.elem_5;
  assign mi[6] = in_i.elem_6;
  assign mi[7] = in_i.elem_7;
  assign mi[8] = in_i.elem_8;

  always_ff @(posedge clk_i) begin
    m1_q   <= mi;
    p_q[0] <= mi[4] * mi[8];
    p_q[1] <= mi[7] * mi[5];
    p_q[2] <= mi[7] * mi[2];
    p_q[3] <= mi[1] * mi[8];
    p_q[4] <= mi[1] * mi[5];
    p_q[5] <= mi[4] * mi[2];
  end

  // Stage 2: cofactors.
  logic signed [15:0] m2_q [9];
  logic signed [32:0] c_q [3];

  always_ff @(posedge clk_i) begin
    m2_q   <= m1_q;
    c_q[0] <= 33'(p_q[0]) - 33'(p_q[1]);
    c_q[1] <= 33'(p_q[2]) - 33'(p_q[3]);
    c_q[2] <= 33'(p_q[4]) - 33'(p_q[5]);
  end

  // Stage 3: determinant terms.
  logic signed [15:0] m3_q [9];
  logic signed [48:0] dt_q [3];

  always_ff @(posedge clk_i) begin
    m3_q     <= m2_q;
    dt_q[0]  <= m2_q[0] * c_q[0];
    dt_q[1]  <= m2_q[3] * c_q[1];
    dt_q[2]  <= m2_q[6] * c_q[2];
  end

  // Stage 4: determinant sign and conditional negation.
  logic signed [50:0] det;
  logic               neg;
  logic signed [16:0] m4_q [9];
  logic               neg4_q;

  assign det = 51'(dt_q[0]) + 51'(dt_q[1]) + 51'(dt_q[2]);
  assign neg = det[50];

  always_ff @(posedge clk_i) begin
    neg4_q <= neg;
    for (int i = 0; i < 9; i++) begin
      m4_q[i] <= neg ? -17'(m3_q[i]) : 17'(m3_q[i]);
    end
  end

  // Stage 5: branch on the diagonal, trace term and raw components.
  logic signed [18:0] e [9];
  logic signed [18:0] t5_d;
  logic signed [18:0] q5_d [4];
  logic signed [18:0] t5_q;
  logic signed [18:0] q5_q [4];
  logic               neg5_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = 19'(m4_q[i]);
    end
    if (e[8] < 0) begin
      if (e[0] > e[4]) begin
        t5_d    = QOne + e[0] - e[4] - e[8];
        q5_d[0] = e[5] - e[7];
        q5_d[1] = t5_d;
        q5_d[2] = e[1] + e[3];
        q5_d[3] = e[2] + e[6];
      end else begin
        t5_d    = QOne - e[0] + e[4] - e[8];
        q5_d[0] = e[6] - e[2];
        q5_d[1] = e[1] + e[3];
        q5_d[2] = t5_d;
        q5_d[3] = e[5] + e[7];
      end
    end else begin
      if (e[0] < -e[4]) begin
        t5_d    = QOne - e[0] - e[4] + e[8];
        q5_d[0] = e[1] - e[3];
        q5_d[1] = e[6] + e[2];
        q5_d[2] = e[5] + e[7];
        q5_d[3] = t5_d;
      end else begin
        t5_d    = QOne + e[0] + e[4] + e[8];
        q5_d[0] = t5_d;
        q5_d[1] = e[5] - e[7];
        q5_d[2] = e[6] - e[2];
        q5_d[3] = e[1] - e[3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t5_q   <= t5_d;
    q5_q   <= q5_d;
    neg5_q <= neg4_q;
  end

  // Stage 6: validity of the trace term and squared magnitudes.
  logic        bad6_q;
  logic        neg6_q;
  logic [16:0] tt6_q;
  logic [3:0]  sgn6_q;
  logic [33:0] sq6_q [4];
  logic [16:0] mag [4];
  logic        bad6;

  assign bad6 = (t5_q <= 0);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = q5_q[i][18] ? 17'(-q5_q[i]) : 17'(q5_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    bad6_q <= bad6;
    neg6_q <= neg5_q;
    tt6_q  <= bad6 ? 17'd1 : t5_q[16:0];
    for (int i = 0; i < 4; i++) begin
      sgn6_q[i] <= q5_q[i][18];
      sq6_q[i]  <= mag[i] * mag[i];
    end
  end

  // Stage 7: divider set-up. The numerator is sq << 14; a quotient of 2^32
  // or more already saturates the result, so only 32 quotient bits are kept.
  pipe_t dv_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    dv_q[0].neg <= neg6_q;
    dv_q[0].bad <= bad6_q;
    dv_q[0].tt  <= tt6_q;
    for (int i = 0; i < 4; i++) begin
      dv_q[0].ln[i].sgn  <= sgn6_q[i];
      dv_q[0].ln[i].ovf  <= ({1'b0, sq6_q[i][33:18]} >= tt6_q);
      dv_q[0].ln[i].rem  <= {3'b0, sq6_q[i][33:18]};
      dv_q[0].ln[i].root <= '0;
      dv_q[0].ln[i].sh   <= {sq6_q[i][17:0], 14'b0};
    end
  end

  // Restoring division, one quotient bit per stage. The quotient shifts in
  // behind the dividend bits that are still to be consumed.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      logic [18:0] r2;
      logic        qb;
      dv_q[k+1].neg <= dv_q[k].neg;
      dv_q[k+1].bad <= dv_q[k].bad;
      dv_q[k+1].tt  <= dv_q[k].tt;
      for (int i = 0; i < 4; i++) begin
        r2 = {dv_q[k].ln[i].rem[17:0], dv_q[k].ln[i].sh[31]};
        qb = (r2 >= {2'b0, dv_q[k].tt});
        dv_q[k+1].ln[i].sgn  <= dv_q[k].ln[i].sgn;
        dv_q[k+1].ln[i].ovf  <= dv_q[k].ln[i].ovf;
        dv_q[k+1].ln[i].root <= '0;
        dv_q[k+1].ln[i].rem  <= qb ? (r2 - {2'b0, dv_q[k].tt}) : r2;
        dv_q[k+1].ln[i].sh   <= {dv_q[k].ln[i].sh[30:0], qb};
      end
    end
  end

  // Digit-by-digit square root of the 32-bit quotient, one root bit a stage.
  pipe_t sq_q [SqrtSteps+1];

  always_comb begin
    sq_q[0] = dv_q[DivSteps];
    for (int i = 0; i < 4; i++) begin
      sq_q[0].ln[i].rem  = '0;
      sq_q[0].ln[i].root = '0;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      logic [18:0] r2;
      logic [18:0] trial;
      logic        rb;
      sq_q[k+1].neg <= sq_q[k].neg;
      sq_q[k+1].bad <= sq_q[k].bad;
      sq_q[k+1].tt  <= sq_q[k].tt;
      for (int i = 0; i < 4; i++) begin
        r2    = {sq_q[k].ln[i].rem[16:0], sq_q[k].ln[i].sh[31:30]};
        trial = {1'b0, sq_q[k].ln[i].root, 2'b01};
        rb    = (r2 >= trial);
        sq_q[k+1].ln[i].sgn  <= sq_q[k].ln[i].sgn;
        sq_q[k+1].ln[i].ovf  <= sq_q[k].ln[i].ovf;
        sq_q[k+1].ln[i].rem  <= rb ? (r2 - trial) : r2;
        sq_q[k+1].ln[i].root <= {sq_q[k].ln[i].root[14:0], rb};
        sq_q[k+1].ln[i].sh   <= {sq_q[k].ln[i].sh[29:0], 2'b00};
      end
    end
  end

  // Output stage: round half away from zero, apply the sign and saturate; bad input gives zero components.
  logic signed [15:0] comp [4];

  always_comb begin
    logic [16:0] n;
    for (int i = 0; i < 4; i++) begin
      n = 17'(({1'b0, sq_q[SqrtSteps].ln[i].root} + 17'd1) >> 1);
      if (sq_q[SqrtSteps].ln[i].ovf) begin
        n = 17'd32768;
      end
      if (sq_q[SqrtSteps].bad) begin
        comp[i] = '0;
      end else if (sq_q[SqrtSteps].ln[i].sgn) begin
        comp[i] = (n >= 17'd32768) ? 16'sh8000 : -$signed(n[15:0]);
      end else begin
        comp[i] = (n >= 17'd32767) ? 16'sh7fff : $signed(n[15:0]);
      end
    end
  end

  quat_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.quat_w    <= comp[0];
    res_q.quat_x    <= comp[1];
    res_q.quat_y    <= comp[2];
    res_q.quat_z    <= comp[3];
    res_q.improper  <= sq_q[SqrtSteps].neg;
    res_q.bad_input <= sq_q[SqrtSteps].bad;
  end

  assign res_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result strobed without a matching accepted transaction");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.bad_input) |->
      (res_o.quat_w == 16'sd0 && res_o.quat_x == 16'sd0 &&
       res_o.quat_y == 16'sd0 && res_o.quat_z == 16'sd0))
    else $error("bad input result carries a non-zero component");

  a_good_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.bad_input) |->
      (res_o.quat_w != 16'sd0 || res_o.quat_x != 16'sd0 ||
       res_o.quat_y != 16'sd0 || res_o.quat_z != 16'sd0))
    else $error("valid result has all components zero");

endmodule
